[hdl/ncsc_pkg.sv]
// Shared types, constants and helpers for the nearest colour signature classifier.
// Used by ncsc_sig_ram, ncsc_dist and nearest_colour_signature_classifier_top.
// No dependencies.
package ncsc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int READING_BITS  = 10;

  localparam int FIELD_W   = 10;  // width of a reading field on the stream
  localparam int ENTRY_W   = 4;   // width of the entry_index / match_index fields
  localparam int DIST_W    = 24;  // width of match_distance
  localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int SQ_W      = 2 * READING_BITS;
  localparam int SUM_W     = 2 * READING_BITS + 4;
  localparam int LVL_WIDE  = READING_BITS + FIELD_W;
  localparam int SAT_W     = (SUM_W > DIST_W) ? SUM_W : DIST_W;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Request kind carried on tuser.
  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  // Piece colour codes.
  localparam logic [1:0] COLOUR_NONE  = 2'd0;
  localparam logic [1:0] COLOUR_WHITE = 2'd1;
  localparam logic [1:0] COLOUR_BLACK = 2'd2;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] REG_HALL_HIGH   = 2'd1;
  localparam logic [1:0] REG_HALL_LOW    = 2'd2;
  localparam logic [1:0] REG_IR_PRESENCE = 2'd3;

  typedef logic [READING_BITS-1:0] level_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } sig_t;

  // Control that travels alongside an entry through the distance pipeline.
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // Bring a stream reading field to the table's reading width.
  function automatic level_t to_level(input logic [FIELD_W-1:0] v);
    logic [LVL_WIDE-1:0] w;
    w = LVL_WIDE'(v);
    return w[READING_BITS-1:0];
  endfunction

endpackage

[hdl/ncsc_sig_ram.sv]
// Signature table: one synchronous memory, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on ncsc_pkg.
module ncsc_sig_ram (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [ncsc_pkg::IDX_W-1:0] waddr,
  input  ncsc_pkg::sig_t            wdata,
  input  logic                      re,
  input  logic [ncsc_pkg::IDX_W-1:0] raddr,
  output ncsc_pkg::sig_t            rdata
);

  ncsc_pkg::sig_t mem [ncsc_pkg::TABLE_ENTRIES];
  logic [ncsc_pkg::TABLE_ENTRIES-1:0] valid;
  ncsc_pkg::sig_t mem_q;
  logic vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        vld_q <= valid[raddr];
      end
    end
  end

  assign rdata = vld_q ? mem_q : '0;

endmodule

[hdl/ncsc_dist.sv]
// Two-stage weighted squared distance unit: squares, then 5*r + 5*g + 4*b.
// Carries a control tag alongside each entry. Depends on ncsc_pkg.
module ncsc_dist (
  input  logic                       clk,
  input  logic                       rst,
  input  ncsc_pkg::tag_t             in_tag,
  input  ncsc_pkg::sig_t             sample,
  input  ncsc_pkg::sig_t             entry,
  output ncsc_pkg::tag_t             out_tag,
  output logic [ncsc_pkg::SUM_W-1:0] dist_sum
);

  ncsc_pkg::level_t dr, dg, db;
  logic [ncsc_pkg::SQ_W-1:0] sq_r, sq_g, sq_b;
  ncsc_pkg::tag_t tag_a;

  always_comb begin
    dr = (sample.red >= entry.red) ? sample.red - entry.red : entry.red - sample.red;
    dg = (sample.green >= entry.green) ? sample.green - entry.green
                                       : entry.green - sample.green;
    db = (sample.blue >= entry.blue) ? sample.blue - entry.blue : entry.blue - sample.blue;
  end

  // Stage A: the three squares in parallel.
  always_ff @(posedge clk) begin
    sq_r <= ncsc_pkg::SQ_W'(dr) * ncsc_pkg::SQ_W'(dr);
    sq_g <= ncsc_pkg::SQ_W'(dg) * ncsc_pkg::SQ_W'(dg);
    sq_b <= ncsc_pkg::SQ_W'(db) * ncsc_pkg::SQ_W'(db);
  end

  // Stage B: weighting by shift and add.
  always_ff @(posedge clk) begin
    dist_sum <= (ncsc_pkg::SUM_W'(sq_r) << 2) + ncsc_pkg::SUM_W'(sq_r)
              + (ncsc_pkg::SUM_W'(sq_g) << 2) + ncsc_pkg::SUM_W'(sq_g)
              + (ncsc_pkg::SUM_W'(sq_b) << 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a   <= '0;
      out_tag <= '0;
    end else begin
      tag_a   <= in_tag;
      out_tag <= tag_a;
    end
  end

endmodule

[hdl/nearest_colour_signature_classifier_top.sv]
// Top level of the nearest colour signature classifier; depends on ncsc_pkg.
// A load writes the table on acceptance; a classify over N = min(entry_count, 16)
// entries reads one entry per cycle with no stall. No new request is taken until a classify's
// result has entered the output register, which waits while an earlier result awaits m_tready.
// Reset (rst, synchronous) clears table valid bits, registers to defaults, sequencer, output.
module nearest_colour_signature_classifier_top (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // From bit 0 up: entry_index[3:0], red_level[13:4], green_level[23:14],
  // blue_level[33:24], hall_level[43:34], ir_level[53:44], zero pad[55:54].
  input  logic [55:0] s_tdata,
  // action: 0 loads a table entry, 1 classifies a sample.
  input  logic        s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // From bit 0 up: match_found[0], match_index[4:1], match_distance[28:5],
  // piece_colour[30:29], piece_present[31].
  output logic [31:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,  // waiting for a request
    ST_SCAN  = 4'b0010,  // issuing one table read per cycle
    ST_DRAIN = 4'b0100,  // waiting for the last entry to leave the distance pipeline
    ST_DONE  = 4'b1000   // result ready, waiting for the output register to free up
  } state_t;

  localparam int CW = (ncsc_pkg::CNT_W > 5) ? ncsc_pkg::CNT_W : 5;

  state_t state;

  // Configuration registers.
  logic [4:0] entry_count;
  logic [9:0] hall_high_threshold;
  logic [9:0] hall_low_threshold;
  logic [9:0] ir_presence_threshold;

  // Request fields.
  logic [ncsc_pkg::ENTRY_W-1:0] in_entry_index;
  logic [ncsc_pkg::FIELD_W-1:0] in_hall, in_ir;
  ncsc_pkg::sig_t in_sig;
  logic in_accept;

  // Sequencer registers.
  ncsc_pkg::sig_t sample;
  logic [ncsc_pkg::CNT_W-1:0] cnt_lim, rd_cnt;
  logic [1:0] colour;
  logic present;

  // Running best.
  logic found;
  logic [ncsc_pkg::SUM_W-1:0] best;
  logic [ncsc_pkg::IDX_W-1:0] best_idx;

  // Memory and pipeline connections.
  logic ram_we, rd_en;
  logic [ncsc_pkg::IDX_W-1:0] ram_waddr;
  ncsc_pkg::sig_t ram_rdata;
  ncsc_pkg::tag_t rd_tag, rd_tag_q, dist_tag;
  logic [ncsc_pkg::SUM_W-1:0] dist_sum;

  // Helper widenings.
  logic [ncsc_pkg::IDX_W+ncsc_pkg::ENTRY_W-1:0] wr_wide, best_wide;
  logic [CW-1:0] ec_wide;
  logic [ncsc_pkg::CNT_W-1:0] count_clamped;
  logic [ncsc_pkg::SAT_W-1:0] best_sat_wide;
  logic [ncsc_pkg::DIST_W-1:0] best_sat;
  logic [1:0] colour_next;
  logic out_load, last_issue;
  logic cfg_write;

  // ---------------------------------------------------------------------------
  // Request unpacking.
  // ---------------------------------------------------------------------------
  assign in_entry_index = s_tdata[3:0];
  assign in_sig.red     = ncsc_pkg::to_level(s_tdata[13:4]);
  assign in_sig.green   = ncsc_pkg::to_level(s_tdata[23:14]);
  assign in_sig.blue    = ncsc_pkg::to_level(s_tdata[33:24]);
  assign in_hall        = s_tdata[43:34];
  assign in_ir          = s_tdata[53:44];

  // Requests are only taken between classifications, so a table write never
  // overlaps a scan read and no forwarding is needed.
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Configuration port. Registers decode on paddr[3:2]; byte offsets are ignored.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count           <= 5'd13;
      hall_high_threshold   <= 10'd1023;
      hall_low_threshold    <= 10'd0;
      ir_presence_threshold <= 10'd600;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        ncsc_pkg::REG_ENTRY_COUNT: entry_count           <= pwdata[4:0];
        ncsc_pkg::REG_HALL_HIGH:   hall_high_threshold   <= pwdata[9:0];
        ncsc_pkg::REG_HALL_LOW:    hall_low_threshold    <= pwdata[9:0];
        ncsc_pkg::REG_IR_PRESENCE: ir_presence_threshold <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ncsc_pkg::REG_ENTRY_COUNT: prdata = 32'(entry_count);
      ncsc_pkg::REG_HALL_HIGH:   prdata = 32'(hall_high_threshold);
      ncsc_pkg::REG_HALL_LOW:    prdata = 32'(hall_low_threshold);
      ncsc_pkg::REG_IR_PRESENCE: prdata = 32'(ir_presence_threshold);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Table loads. An index beyond the table is dropped.
  // ---------------------------------------------------------------------------
  assign wr_wide   = (ncsc_pkg::IDX_W + ncsc_pkg::ENTRY_W)'(in_entry_index);
  assign ram_waddr = wr_wide[ncsc_pkg::IDX_W-1:0];
  assign ram_we    = in_accept && (s_tuser == ncsc_pkg::ACT_LOAD) &&
                     (wr_wide < (ncsc_pkg::IDX_W + ncsc_pkg::ENTRY_W)'(ncsc_pkg::TABLE_ENTRIES));

  // ---------------------------------------------------------------------------
  // Classify setup: clamp the search count and classify hall and IR right away.
  // ---------------------------------------------------------------------------
  assign ec_wide       = CW'(entry_count);
  assign count_clamped = (ec_wide > CW'(ncsc_pkg::TABLE_ENTRIES))
                         ? ncsc_pkg::CNT_W'(ncsc_pkg::TABLE_ENTRIES)
                         : ec_wide[ncsc_pkg::CNT_W-1:0];

  // The high test wins over the low test.
  always_comb begin
    if (in_hall > hall_high_threshold) begin
      colour_next = ncsc_pkg::COLOUR_WHITE;
    end else if (in_hall < hall_low_threshold) begin
      colour_next = ncsc_pkg::COLOUR_BLACK;
    end else begin
      colour_next = ncsc_pkg::COLOUR_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan: one table read per cycle, each tagged with its index and a last mark.
  // ---------------------------------------------------------------------------
  assign rd_en      = (state == ST_SCAN);
  assign last_issue = (rd_cnt == cnt_lim - ncsc_pkg::CNT_W'(1));

  always_comb begin
    rd_tag.vld  = rd_en;
    rd_tag.last = last_issue;
    rd_tag.idx  = rd_cnt[ncsc_pkg::IDX_W-1:0];
  end

  // The tag is registered to line up with the registered memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag_q <= '0;
    end else begin
      rd_tag_q <= rd_tag;
    end
  end

  ncsc_sig_ram u_sig_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_sig),
    .re    (rd_en),
    .raddr (rd_cnt[ncsc_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  ncsc_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_tag   (rd_tag_q),
    .sample   (sample),
    .entry    (ram_rdata),
    .out_tag  (dist_tag),
    .dist_sum (dist_sum)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and running minimum. The first entry always takes the lead, and a
  // later one replaces it only when strictly nearer, so a tie keeps the lower index.
  // ---------------------------------------------------------------------------
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (in_accept && (s_tuser == ncsc_pkg::ACT_CLASSIFY)) begin
      sample  <= in_sig;
      cnt_lim <= count_clamped;
      colour  <= colour_next;
      present <= (in_ir > ir_presence_threshold);
    end
    if (dist_tag.vld && (!found || dist_sum < best)) begin
      best     <= dist_sum;
      best_idx <= dist_tag.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_cnt <= '0;
      found  <= 1'b0;
    end else begin
      if (dist_tag.vld) begin
        found <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept && (s_tuser == ncsc_pkg::ACT_CLASSIFY)) begin
            found  <= 1'b0;
            rd_cnt <= '0;
            state  <= (count_clamped == '0) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_cnt <= rd_cnt + ncsc_pkg::CNT_W'(1);
          if (last_issue) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (dist_tag.vld && dist_tag.last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. Distances beyond 24 bits saturate; an empty search reports
  // index and distance zero.
  // ---------------------------------------------------------------------------
  assign best_sat_wide = ncsc_pkg::SAT_W'(best);
  assign best_sat      = (best_sat_wide > ncsc_pkg::SAT_W'(ncsc_pkg::DIST_MAX))
                         ? ncsc_pkg::DIST_MAX : best_sat_wide[ncsc_pkg::DIST_W-1:0];
  assign best_wide     = (ncsc_pkg::IDX_W + ncsc_pkg::ENTRY_W)'(best_idx);

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[0]     <= found;
      m_tdata[4:1]   <= found ? best_wide[ncsc_pkg::ENTRY_W-1:0] : '0;
      m_tdata[28:5]  <= found ? best_sat : '0;
      m_tdata[30:29] <= colour;
      m_tdata[31]    <= present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A table write never lands in the same cycle as a scan read.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && rd_en))
    else $error("table write overlaps a scan read");

  // The output register is never overwritten while it holds an untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
    else $error("pending result overwritten");

  // An empty search reports index and distance zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[28:1] == '0))
    else $error("empty search carries a nonzero index or distance");

  // Results from the distance pipeline only arrive while a classification runs.
  a_dist_in_scan: assert property (@(posedge clk) disable iff (rst)
    dist_tag.vld |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("distance result outside a scan");

endmodule
